[src/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the scheduling latency tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int SLOT_W = 10;
    localparam int CPU_W  = 3;
    localparam int TIME_W = 64;
    localparam int RUNS_W = 32;
    localparam int CNT_W  = 32;

    localparam logic [1:0] ACT_WAKEUP = 2'd0;
    localparam logic [1:0] ACT_NEW    = 2'd1;
    localparam logic [1:0] ACT_SWITCH = 2'd2;
    localparam logic [1:0] ACT_EXIT   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] task_req;
        logic [CPU_W-1:0]  cpu;
        logic [SLOT_W-1:0] prev_task;
        logic              prev_running;
        logic [TIME_W-1:0] time_ns;
    } t_in_item;

    typedef struct packed {
        logic              sample_valid;
        logic [SLOT_W-1:0] sampled_task;
        logic [TIME_W-1:0] delay_ns;
        logic [RUNS_W-1:0] task_runs;
        logic [CNT_W-1:0]  total_samples;
        logic [TIME_W-1:0] total_delay_ns;
        logic [TIME_W-1:0] max_delay_ns;
        logic [TIME_W-1:0] min_delay_ns;
        logic [SLOT_W-1:0] older_prev_task;
        logic [SLOT_W-1:0] newer_prev_task;
    } t_out_item;

endpackage

`default_nettype wire

[src/sched_latency_tracker_core.sv]
// ----------------------------------------------------------------------------
// sched_latency_tracker_core
// Per-task wakeup-to-run latency tracker with system totals.
// ----------------------------------------------------------------------------
// The task table (TASK_SLOTS + IDLE_CPUS entries, one per task slot plus one
// idle entry per cpu) lives in a RAM with one read and one write port and a
// registered read. After reset a clearing pass writes every entry to zero, one
// per cycle; input stays stalled until it ends. With tracking enabled, each
// transaction then does one read-modify-write of its table entry, through the
// main and then the emit state; a switch that yields a sample also passes the
// stat state before emit, and a switch whose incoming task has no entry leaves
// it unwritten. A switch whose outgoing task is still running passes the prev
// state before main, since the outgoing task's entry is refreshed through the
// same RAM first. With tracking disabled a transaction goes from idle straight
// to emit. A result is produced for every transaction (sample_valid low when
// no sample was taken) and is held in an output register, so the next
// transaction can be taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sched_latency_tracker_core #(
    parameter int TASK_SLOTS = 1024,
    parameter int IDLE_CPUS  = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire slt_pkg::t_in_item    i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output slt_pkg::t_out_item        o_out_data
);

    localparam int ENTRIES = TASK_SLOTS + IDLE_CPUS;
    localparam int AW      = $clog2(ENTRIES);
    localparam int SLOT_QB = $clog2(((1 << slt_pkg::SLOT_W) - 1) / TASK_SLOTS + 1);
    localparam int CPU_QB  = $clog2(((1 << slt_pkg::CPU_W) - 1) / IDLE_CPUS + 1);

    typedef struct packed {
        logic                         valid;
        logic                         seen;
        logic [slt_pkg::RUNS_W-1:0]   runs;
        logic [slt_pkg::TIME_W-1:0]   enq;
        logic [slt_pkg::SLOT_W-1:0]   newer;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREV,
        S_MAIN,
        S_STAT,
        S_EMIT
    } t_state;

    function automatic logic [AW-1:0] entry_of(logic [slt_pkg::SLOT_W-1:0] slot,
                                               logic [slt_pkg::CPU_W-1:0] cpu);
        logic [31:0] r;
        logic [31:0] c;
        r = 32'(slot);
        c = 32'(cpu);
        for (int k = SLOT_QB - 1; k >= 0; k--) begin
            if (r >= (32'(TASK_SLOTS) << k)) begin
                r = r - (32'(TASK_SLOTS) << k);
            end
        end
        for (int k = CPU_QB - 1; k >= 0; k--) begin
            if (c >= (32'(IDLE_CPUS) << k)) begin
                c = c - (32'(IDLE_CPUS) << k);
            end
        end
        if (slot == '0) begin
            r = 32'(TASK_SLOTS) + c;
        end
        return r[AW-1:0];
    endfunction

    function automatic t_entry create(t_entry d, logic [slt_pkg::TIME_W-1:0] now);
        t_entry e;
        e       = d;
        e.valid = 1'b1;
        e.seen  = 1'b0;
        e.runs  = slt_pkg::RUNS_W'(1);
        e.enq   = now;
        return e;
    endfunction

    function automatic t_entry touch(t_entry d, logic [slt_pkg::TIME_W-1:0] now);
        t_entry e;
        e = d;
        if (d.valid) begin
            e.enq = now;
        end else begin
            e = create(d, now);
        end
        return e;
    endfunction

    t_state                       r_state;
    logic [AW-1:0]                r_clr_idx;
    logic                         r_enable;
    slt_pkg::t_in_item            r_item;
    logic [AW-1:0]                r_e;
    logic                         r_fwd_hit;
    t_entry                       r_fwd_data;
    logic [slt_pkg::TIME_W-1:0]   r_delay;
    logic [slt_pkg::RUNS_W-1:0]   r_runs;
    logic [slt_pkg::SLOT_W-1:0]   r_older;
    logic [slt_pkg::CNT_W-1:0]    r_sample_count;
    logic [slt_pkg::TIME_W-1:0]   r_delay_sum;
    logic [slt_pkg::TIME_W-1:0]   r_delay_max;
    logic [slt_pkg::TIME_W-1:0]   r_delay_min;
    slt_pkg::t_out_item           r_res;
    logic                         r_out_valid;
    slt_pkg::t_out_item           r_out_data;

    t_entry                       r_table [ENTRIES];
    t_entry                       r_rd_data;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [AW-1:0]                mem_raddr;
    t_entry                       mem_wdata;

    logic                         accept;
    logic                         in_prev_touch;
    logic [AW-1:0]                in_e;
    logic [AW-1:0]                in_pe;
    t_entry                       main_d;
    t_entry                       prev_w;
    logic                         main_sample;
    logic [slt_pkg::TIME_W-1:0]   main_delay;
    logic [slt_pkg::CNT_W-1:0]    n_sample_count;
    logic [slt_pkg::TIME_W-1:0]   n_delay_sum;
    logic [slt_pkg::TIME_W-1:0]   n_delay_max;
    logic [slt_pkg::TIME_W-1:0]   n_delay_min;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    assign in_e          = entry_of(i_in_data.task_req, i_in_data.cpu);
    assign in_pe         = entry_of(i_in_data.prev_task, i_in_data.cpu);
    assign in_prev_touch = (i_in_data.action == slt_pkg::ACT_SWITCH) && i_in_data.prev_running;

    assign prev_w      = touch(r_rd_data, r_item.time_ns);
    assign main_d      = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign main_sample = (r_item.action == slt_pkg::ACT_SWITCH) && main_d.valid;
    assign main_delay  = r_item.time_ns - main_d.enq;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_e;
        mem_wdata = main_d;
        mem_raddr = r_e;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
            end
            S_IDLE: begin
                mem_raddr = in_prev_touch ? in_pe : in_e;
            end
            S_PREV: begin
                mem_we    = 1'b1;
                mem_waddr = entry_of(r_item.prev_task, r_item.cpu);
                mem_wdata = prev_w;
            end
            S_MAIN: begin
                unique case (r_item.action)
                    slt_pkg::ACT_WAKEUP: begin
                        mem_we    = 1'b1;
                        mem_wdata = touch(main_d, r_item.time_ns);
                    end
                    slt_pkg::ACT_NEW: begin
                        mem_we    = 1'b1;
                        mem_wdata = create(main_d, r_item.time_ns);
                    end
                    slt_pkg::ACT_EXIT: begin
                        mem_we          = 1'b1;
                        mem_wdata.valid = 1'b0;
                        mem_wdata.seen  = 1'b0;
                    end
                    default: begin
                        mem_we          = main_d.valid;
                        mem_wdata.seen  = 1'b1;
                        mem_wdata.runs  = main_d.seen ? main_d.runs + 1'b1 : main_d.runs;
                        mem_wdata.newer = r_item.prev_task;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_sample_count = r_sample_count + 1'b1;
        n_delay_sum    = r_delay_sum + r_delay;
        n_delay_max    = r_delay_max;
        n_delay_min    = r_delay_min;
        if (r_delay > r_delay_max) begin
            n_delay_max = r_delay;
        end else if (r_delay_min == '0 || r_delay < r_delay_min) begin
            n_delay_min = r_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_table[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_idx      <= '0;
            r_enable       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_fwd_hit      <= 1'b0;
            r_sample_count <= '0;
            r_delay_sum    <= '0;
            r_delay_max    <= '0;
            r_delay_min    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == AW'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_item    <= i_in_data;
                        r_e       <= in_e;
                        r_fwd_hit <= 1'b0;
                        r_res     <= '0;
                        if (!r_enable) begin
                            r_state <= S_EMIT;
                        end else if (in_prev_touch) begin
                            r_state <= S_PREV;
                        end else begin
                            r_state <= S_MAIN;
                        end
                    end
                end
                S_PREV: begin
                    // same entry for prev and next: RAM read returns old data
                    r_fwd_hit  <= (entry_of(r_item.prev_task, r_item.cpu) == r_e);
                    r_fwd_data <= prev_w;
                    r_state    <= S_MAIN;
                end
                S_MAIN: begin
                    r_delay  <= main_delay;
                    r_runs   <= main_d.seen ? main_d.runs + 1'b1 : main_d.runs;
                    r_older  <= main_d.newer;
                    r_state  <= main_sample ? S_STAT : S_EMIT;
                end
                S_STAT: begin
                    r_sample_count        <= n_sample_count;
                    r_delay_sum           <= n_delay_sum;
                    r_delay_max           <= n_delay_max;
                    r_delay_min           <= n_delay_min;
                    r_res.sample_valid    <= 1'b1;
                    r_res.sampled_task    <= r_item.task_req;
                    r_res.delay_ns        <= r_delay;
                    r_res.task_runs       <= r_runs;
                    r_res.total_samples   <= n_sample_count;
                    r_res.total_delay_ns  <= n_delay_sum;
                    r_res.max_delay_ns    <= n_delay_max;
                    r_res.min_delay_ns    <= n_delay_min;
                    r_res.older_prev_task <= r_older;
                    r_res.newer_prev_task <= r_item.prev_task;
                    r_state               <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/sv/slt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_checker
// Watches both channels of the latency tracker, predicts each result from
// its own copy of the task table and system totals, and compares field by
// field in order. Counts failures and reports the number of open results.
// ----------------------------------------------------------------------------
module slt_checker
    import slt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_data,
    output int             o_fail_count,
    output int             o_outstanding
);

    localparam int TASK_SLOTS = 1024;
    localparam int IDLE_CPUS  = 8;
    localparam int ENTRIES    = TASK_SLOTS + IDLE_CPUS;

    logic              tbl_valid [ENTRIES];
    logic              tbl_seen  [ENTRIES];
    logic [RUNS_W-1:0] tbl_runs  [ENTRIES];
    logic [TIME_W-1:0] tbl_enq   [ENTRIES];
    logic              hist_valid[ENTRIES];
    logic [SLOT_W-1:0] hist_newer[ENTRIES];

    logic [CNT_W-1:0]  n_samples;
    logic [TIME_W-1:0] delay_total;
    logic [TIME_W-1:0] delay_hi;
    logic [TIME_W-1:0] delay_lo;
    logic              tracking_on;

    t_out_item latency_q[$];
    t_out_item want;
    int        fails = 0;

    assign o_fail_count = fails;

    function automatic int entry_index(input logic [SLOT_W-1:0] slot,
                                       input logic [CPU_W-1:0] cpu);
        if (slot == '0) return TASK_SLOTS + (cpu % IDLE_CPUS);
        return slot % TASK_SLOTS;
    endfunction

    function automatic void stamp_entry(input int idx, input logic [TIME_W-1:0] now,
                                        input bit recreate);
        if (recreate || !tbl_valid[idx]) begin
            tbl_valid[idx] = 1'b1;
            tbl_seen[idx]  = 1'b0;
            tbl_runs[idx]  = RUNS_W'(1);
        end
        tbl_enq[idx] = now;
    endfunction

    function automatic void clear_tracker();
        for (int k = 0; k < ENTRIES; k++) begin
            tbl_valid[k]  = 1'b0;
            tbl_seen[k]   = 1'b0;
            tbl_runs[k]   = '0;
            tbl_enq[k]    = '0;
            hist_valid[k] = 1'b0;
            hist_newer[k] = '0;
        end
        n_samples   = '0;
        delay_total = '0;
        delay_hi    = '0;
        delay_lo    = '0;
        tracking_on = 1'b0;
    endfunction

    function automatic t_out_item predict_latency(input t_in_item ev);
        t_out_item         res;
        int                idx;
        logic [TIME_W-1:0] delay;
        logic [SLOT_W-1:0] older;
        res = '0;
        if (!tracking_on) return res;
        idx = entry_index(ev.task_req, ev.cpu);
        case (ev.action)
            ACT_WAKEUP: stamp_entry(idx, ev.time_ns, 1'b0);
            ACT_NEW:    stamp_entry(idx, ev.time_ns, 1'b1);
            ACT_EXIT: begin
                tbl_valid[idx] = 1'b0;
                tbl_seen[idx]  = 1'b0;
            end
            ACT_SWITCH: begin
                // outgoing task still runnable: back on the queue now
                if (ev.prev_running)
                    stamp_entry(entry_index(ev.prev_task, ev.cpu), ev.time_ns, 1'b0);
                if (tbl_valid[idx]) begin
                    if (tbl_seen[idx]) tbl_runs[idx] = tbl_runs[idx] + 1'b1;
                    else tbl_seen[idx] = 1'b1;
                    delay       = ev.time_ns - tbl_enq[idx];
                    n_samples   = n_samples + 1'b1;
                    delay_total = delay_total + delay;
                    if (delay > delay_hi) delay_hi = delay;
                    else if (delay_lo == '0 || delay < delay_lo) delay_lo = delay;
                    older = hist_valid[idx] ? hist_newer[idx] : '0;
                    hist_newer[idx] = ev.prev_task;
                    hist_valid[idx] = 1'b1;
                    res.sample_valid    = 1'b1;
                    res.sampled_task    = ev.task_req;
                    res.delay_ns        = delay;
                    res.task_runs       = tbl_runs[idx];
                    res.total_samples   = n_samples;
                    res.total_delay_ns  = delay_total;
                    res.max_delay_ns    = delay_hi;
                    res.min_delay_ns    = delay_lo;
                    res.older_prev_task = older;
                    res.newer_prev_task = ev.prev_task;
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tracker();
            latency_q.delete();
        end else begin
            if (i_cfg_we) tracking_on = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) latency_q.push_back(predict_latency(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (latency_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    fails++;
                end else begin
                    want = latency_q.pop_front();
                    check_field("sample_valid", want.sample_valid, i_out_data.sample_valid);
                    check_field("sampled_task", want.sampled_task, i_out_data.sampled_task);
                    check_field("delay_ns", want.delay_ns, i_out_data.delay_ns);
                    check_field("task_runs", want.task_runs, i_out_data.task_runs);
                    check_field("total_samples", want.total_samples,
                                i_out_data.total_samples);
                    check_field("total_delay_ns", want.total_delay_ns,
                                i_out_data.total_delay_ns);
                    check_field("max_delay_ns", want.max_delay_ns, i_out_data.max_delay_ns);
                    check_field("min_delay_ns", want.min_delay_ns, i_out_data.min_delay_ns);
                    check_field("older_prev_task", want.older_prev_task,
                                i_out_data.older_prev_task);
                    check_field("newer_prev_task", want.newer_prev_task,
                                i_out_data.newer_prev_task);
                end
            end
        end
        o_outstanding <= latency_q.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the latency tracker with directed scheduler events, then random
// event streams over a small set of tasks, across enable settings, with
// random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import slt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 12;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int sent_count  = 0;
    int tx_gap_pct  = 0;
    bit rx_idle_on  = 1'b0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int burst_left  = 0;

    logic [SLOT_W-1:0] task_pool[POOL_SIZE];
    logic [TIME_W-1:0] sim_now = '0;

    sched_latency_tracker_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    slt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sched_latency_tracker_core: mismatch");
            $finish;
        end
    end

    // result side: one long hold-off to back the block up, and random bursts while idling is on
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && sent_count >= 300) begin
            i_out_stall <= 1'b1;
            hold_left   <= 150;
            hold_done   <= 1'b1;
        end else if (burst_left > 0) begin
            i_out_stall <= 1'b1;
            burst_left  <= burst_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            burst_left  <= $urandom_range(0, 10);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input t_in_item ev);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count <= sent_count + 1;
    endtask

    task automatic send_event(input logic [1:0] act, input logic [SLOT_W-1:0] slot,
                              input logic [CPU_W-1:0] cpu, input logic [SLOT_W-1:0] prev,
                              input logic running, input logic [TIME_W-1:0] t);
        t_in_item ev;
        ev.action       = act;
        ev.task_req     = slot;
        ev.cpu          = cpu;
        ev.prev_task    = prev;
        ev.prev_running = running;
        ev.time_ns      = t;
        send_item(ev);
    endtask

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 19) == 0) return SLOT_W'($urandom_range(0, 1023));
        return task_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // mostly forward-moving time over a few tasks; rare jumps anywhere
    function automatic t_in_item next_sched_event();
        t_in_item ev;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      ev.action = ACT_WAKEUP;
        else if (pick < 45) ev.action = ACT_NEW;
        else if (pick < 88) ev.action = ACT_SWITCH;
        else                ev.action = ACT_EXIT;
        ev.task_req     = pick_slot();
        ev.prev_task    = pick_slot();
        ev.cpu          = CPU_W'($urandom_range(0, 7));
        ev.prev_running = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 49) == 0) sim_now = {$urandom, $urandom};
        else sim_now = sim_now + $urandom_range(0, 5000);
        ev.time_ns = sim_now;
        return ev;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_item(next_sched_event());
    endtask

    task automatic drain_and_set(input logic value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        task_pool[0] = '0;
        for (int k = 1; k < POOL_SIZE; k++) task_pool[k] = SLOT_W'($urandom_range(1, 1023));
        rx_idle_on <= 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 1'b0;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;

        // tracking off: nothing may stick
        tx_gap_pct = 30;
        send_event(ACT_WAKEUP, 10'd99, 3'd1, 10'd0, 1'b0, 64'd10);
        send_event(ACT_NEW, 10'd99, 3'd1, 10'd0, 1'b0, 64'd20);
        send_event(ACT_SWITCH, 10'd99, 3'd1, 10'd99, 1'b1, 64'd30);
        drain_and_set(1'b1);

        send_event(ACT_SWITCH, 10'd99, 3'd0, 10'd0, 1'b0, 64'd4000);
        send_event(ACT_WAKEUP, 10'd1023, 3'd7, 10'd0, 1'b0, 64'd1000);
        send_event(ACT_SWITCH, 10'd1023, 3'd7, 10'd0, 1'b0, 64'd1500);
        send_event(ACT_WAKEUP, 10'd1023, 3'd7, 10'd0, 1'b0, 64'd1600);
        send_event(ACT_SWITCH, 10'd1023, 3'd2, 10'd5, 1'b0, 64'd1700);
        send_event(ACT_SWITCH, 10'd1023, 3'd2, 10'd6, 1'b0, 64'd1750);
        send_event(ACT_NEW, 10'd512, 3'd3, 10'd0, 1'b0, 64'd2000);
        send_event(ACT_SWITCH, 10'd512, 3'd3, 10'd512, 1'b1, 64'd2500);
        send_event(ACT_WAKEUP, 10'd0, 3'd0, 10'd0, 1'b0, 64'd3000);
        send_event(ACT_SWITCH, 10'd0, 3'd0, 10'd1023, 1'b1, 64'd3010);
        send_event(ACT_WAKEUP, 10'd0, 3'd7, 10'd0, 1'b0, 64'd3100);
        send_event(ACT_SWITCH, 10'd0, 3'd7, 10'd0, 1'b1, 64'd3120);
        send_event(ACT_EXIT, 10'd1023, 3'd0, 10'd0, 1'b0, 64'd3200);
        send_event(ACT_SWITCH, 10'd1023, 3'd1, 10'd512, 1'b0, 64'd3300);
        send_event(ACT_SWITCH, 10'd77, 3'd1, 10'd0, 1'b0, 64'd3400);
        send_event(ACT_NEW, 10'd512, 3'd0, 10'd0, 1'b0, 64'd3500);
        send_event(ACT_SWITCH, 10'd512, 3'd4, 10'd1023, 1'b0, 64'd3600);
        send_event(ACT_WAKEUP, 10'd200, 3'd5, 10'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_event(ACT_SWITCH, 10'd200, 3'd5, 10'd341, 1'b0, 64'h10);
        send_event(ACT_WAKEUP, 10'd682, 3'd6, 10'd0, 1'b0, 64'd0);
        send_event(ACT_SWITCH, 10'd682, 3'd6, 10'd1023, 1'b0, '1);
        send_event(ACT_SWITCH, 10'd1023, 3'd6, 10'd682, 1'b1, 64'd20);

        tx_gap_pct = 25;
        run_random(450);
        drain_and_set(1'b0);
        run_random(5);
        drain_and_set(1'b1);
        tx_gap_pct = 10;
        run_random(250);

        // closing stretch at full rate on both sides
        tx_gap_pct = 0;
        rx_idle_on <= 1'b0;
        run_random(250);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("sched_latency_tracker_core: match");
        end else begin
            $display("sched_latency_tracker_core: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
src/slt_pkg.sv
src/sched_latency_tracker_core.sv
tb/sv/slt_checker.sv
tb/sv/testbench.sv
